/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* rtl/ssa_pkg.sv */
`default_nettype none

package ssa_pkg;

	localparam int unsigned WORD_W = 64;

	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_HOP    = 2'd1;
	localparam logic [1:0] OP_ASSIGN = 2'd2;

	localparam logic POLICY_FIRST_FIT = 1'b0;
	localparam logic POLICY_MOST_USED = 1'b1;

	typedef struct packed {
		logic [1:0]        operation;
		logic [3:0]        from_node;
		logic [3:0]        to_node;
		logic [WORD_W-1:0] occupancy_word;
		logic [6:0]        slots_required;
	} in_item_t;

	typedef struct packed {
		logic       found;
		logic [5:0] start_slot;
		logic [6:0] slots_used;
	} out_item_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic exec;
		logic step;
		logic deliver;
	} ssa_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_last;
		logic out_hold;
	} ssa_status_t;

endpackage

`default_nettype wire

/* rtl/ssa_ram.sv */
`default_nettype none

module ssa_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/ssa_ctrl.sv */
`default_nettype none
`include "assert_macros.svh"

module ssa_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic [1:0]          in_op,
	output logic                     in_stall,
	output ssa_pkg::ssa_cmd_t        cmd,
	input  wire ssa_pkg::ssa_status_t status
);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_EXEC = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLR: begin
				cmd.clr = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					if (in_op inside {ssa_pkg::OP_WRITE, ssa_pkg::OP_HOP}) begin
						state_d = ST_EXEC;
					end else if (in_op == ssa_pkg::OP_ASSIGN) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (status.scan_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!status.out_hold) begin
					cmd.deliver = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_CLK(a_assign_holds_input, clk, arst_n, (accept && in_op == ssa_pkg::OP_ASSIGN) |=> in_stall, "input taken during assign")
	`ASSERT_NEVER(a_deliver_when_held, clk, arst_n, cmd.deliver && status.out_hold, "result overwrote held item")

endmodule

`default_nettype wire

/* rtl/ssa_dp.sv */
`default_nettype none
`include "assert_macros.svh"

module ssa_dp #(
	parameter int unsigned NUM_SLOTS = 64,
	parameter int unsigned NUM_NODES = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ssa_pkg::ssa_cmd_t    cmd,
	output ssa_pkg::ssa_status_t      status,
	input  wire logic                 policy,
	input  wire ssa_pkg::in_item_t    in_item,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output ssa_pkg::out_item_t        out_item
);

	localparam int unsigned WW         = ssa_pkg::WORD_W;
	localparam int unsigned LINK_COUNT = NUM_NODES * NUM_NODES;
	localparam int unsigned AW         = $clog2(LINK_COUNT);
	localparam int unsigned SLW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int unsigned CW         = $clog2(LINK_COUNT + 1);
	localparam int unsigned RW         = $clog2(NUM_SLOTS + 1);
	localparam int unsigned SW         = CW + RW;

	// latched item
	logic [1:0]     op_q;
	logic           range_ok_q;
	logic [AW-1:0]  idx_q;
	logic [WW-1:0]  word_q;
	logic [6:0]     req_q;
	logic           req_ok_q;

	logic [AW-1:0]  clr_q;
	logic [WW-1:0]  mask_q;
	logic [CW-1:0]  cnt_q [NUM_SLOTS];

	// scan state
	logic [SLW-1:0] b_q;
	logic [RW-1:0]  run_q;
	logic [SW-1:0]  sum_q;
	logic [SW-1:0]  best_q;
	logic           found_q;
	logic [5:0]     start_q;
	logic [CW-1:0]  prev_head_q;

	logic                out_valid_q;
	ssa_pkg::out_item_t  out_q;

	logic           in_range;
	logic [AW-1:0]  in_idx;
	logic           link_we;
	logic [AW-1:0]  link_waddr;
	logic [WW-1:0]  link_wdata;
	logic [WW-1:0]  link_rdata;
	logic           wr_exec;
	logic           hop_exec;

	logic [CW-1:0]  head;
	logic [CW-1:0]  buf_rdata;
	logic [CW-1:0]  out_w;
	logic [7:0]     b_ext;
	logic [7:0]     req_ext;
	logic [7:0]     nxt;
	logic [RW-1:0]  run_n;
	logic [SW-1:0]  sum_n;
	logic           hit;
	logic           take;

	assign in_range = (7'(in_item.from_node) < 7'(NUM_NODES))
		&& (7'(in_item.to_node) < 7'(NUM_NODES));
	assign in_idx = AW'(int'(in_item.from_node) * int'(NUM_NODES) + int'(in_item.to_node));

	assign wr_exec  = cmd.exec && range_ok_q && (op_q == ssa_pkg::OP_WRITE);
	assign hop_exec = cmd.exec && range_ok_q && (op_q == ssa_pkg::OP_HOP);

	assign link_we    = cmd.clr || wr_exec;
	assign link_waddr = cmd.clr ? clr_q : idx_q;
	assign link_wdata = cmd.clr ? '0 : word_q;

	ssa_ram #(
		.WIDTH (WW),
		.DEPTH (LINK_COUNT)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (in_idx),
		.rdata (link_rdata)
	);

	// window tail: weights of the slots already passed
	assign head    = cnt_q[0];
	assign b_ext   = 8'(b_q);
	assign req_ext = {1'b0, req_q};
	assign nxt     = b_ext + 8'd1 - req_ext;

	ssa_ram #(
		.WIDTH (CW),
		.DEPTH (NUM_SLOTS)
	) u_weight_buf (
		.clk   (clk),
		.we    (cmd.step),
		.waddr (b_q),
		.wdata (head),
		.raddr (SLW'(nxt)),
		.rdata (buf_rdata)
	);

	always_comb begin
		out_w = '0;
		if (b_ext >= req_ext) begin
			out_w = (req_q == 7'd1) ? prev_head_q : buf_rdata;
		end
	end

	assign run_n = mask_q[0] ? '0 : run_q + RW'(1);
	assign sum_n = sum_q + SW'(head) - SW'(out_w);
	assign hit   = req_ok_q && (8'(run_n) >= req_ext);
	assign take  = hit && (!found_q || (policy == ssa_pkg::POLICY_MOST_USED && sum_n > best_q));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= in_item.operation;
			range_ok_q <= in_range;
			idx_q      <= in_idx;
			word_q     <= in_item.occupancy_word;
			req_q      <= in_item.slots_required;
			req_ok_q   <= (in_item.slots_required != 7'd0)
				&& ({1'b0, in_item.slots_required} <= 8'(NUM_SLOTS));
		end
		if (cmd.step) begin
			prev_head_q <= head;
		end
	end

	// per-slot count of occupied links, rotated once around during a scan
	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cnt
		logic [CW-1:0] rot_next;
		if (i == NUM_SLOTS - 1) begin : g_wrap
			assign rot_next = cnt_q[0];
		end else begin : g_shift
			assign rot_next = cnt_q[i + 1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q[i] <= '0;
			end else if (wr_exec) begin
				cnt_q[i] <= cnt_q[i] + CW'(word_q[i]) - CW'(link_rdata[i]);
			end else if (cmd.step) begin
				cnt_q[i] <= rot_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			mask_q  <= '0;
			b_q     <= '0;
			run_q   <= '0;
			sum_q   <= '0;
			best_q  <= '0;
			found_q <= 1'b0;
			start_q <= '0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (hop_exec) begin
				mask_q <= mask_q | link_rdata;
			end else if (cmd.deliver) begin
				mask_q <= '0;
			end else if (cmd.step) begin
				mask_q <= mask_q >> 1;
			end
			if (cmd.load) begin
				b_q     <= '0;
				run_q   <= '0;
				sum_q   <= '0;
				best_q  <= '0;
				found_q <= 1'b0;
				start_q <= '0;
			end else if (cmd.step) begin
				b_q   <= status.scan_last ? '0 : b_q + SLW'(1);
				run_q <= run_n;
				sum_q <= sum_n;
				if (take) begin
					found_q <= 1'b1;
					best_q  <= sum_n;
					start_q <= 6'(nxt);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.deliver) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.deliver) begin
			out_q.found      <= found_q;
			out_q.start_slot <= found_q ? start_q : 6'd0;
			out_q.slots_used <= found_q ? req_q : 7'd0;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_item         = out_q;
	assign status.clr_last  = (clr_q == AW'(LINK_COUNT - 1));
	assign status.scan_last = (b_q == SLW'(NUM_SLOTS - 1));
	assign status.out_hold  = out_valid_q && out_stall;

	`ASSERT_CLK(a_scan_wraps, clk, arst_n, (cmd.step && status.scan_last) |=> (b_q == '0), "slot index did not wrap")
	`ASSERT_NEVER(a_found_has_slots, clk, arst_n, out_valid_q && out_q.found && out_q.slots_used == 7'd0, "grant with no slots")

endmodule

`default_nettype wire

/* rtl/spectrum_slot_assigner_top.sv */
// spectrum slot assigner
// input channel in_valid/in_stall/in_item: write a link word, add a hop to
// the route, or assign a window of slots on the route built so far.
// result channel out_valid/out_stall/out_item: one item per assign, none
// for write or hop. cfg_we/cfg_wdata set the policy, 0 first fit,
// 1 most used window; write it only while the block is idle.
// after reset all NUM_NODES*NUM_NODES link words (256 by default) are
// swept to zero with in_stall high; the policy resets to first fit.
// write and hop pass through an exec state that uses the registered
// read of the link store. assign scans the route, then delivers its
// result from a done state, raising out_valid, and is ready for the next
// item as out_valid rises: one slot of the route is examined per cycle, with
// running window sums drawn from per-slot counters of occupied links.
// the result sits in an output register, so the next item is accepted
// while it waits; if out_stall holds it and a second assign finishes,
// that assign waits until the first result is taken.
`default_nettype none

module spectrum_slot_assigner_top #(
	parameter int unsigned NUM_SLOTS = 64,
	parameter int unsigned NUM_NODES = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire ssa_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output ssa_pkg::out_item_t      out_item,
	input  wire logic               cfg_we,
	input  wire logic               cfg_wdata
);

	logic                 policy_q;
	ssa_pkg::ssa_cmd_t    cmd;
	ssa_pkg::ssa_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= ssa_pkg::POLICY_FIRST_FIT;
		end else if (cfg_we) begin
			policy_q <= cfg_wdata;
		end
	end

	ssa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_item.operation),
		.in_stall (in_stall),
		.cmd      (cmd),
		.status   (status)
	);

	ssa_dp #(
		.NUM_SLOTS (NUM_SLOTS),
		.NUM_NODES (NUM_NODES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.policy    (policy_q),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire
